>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the dispatcher.
// Depends on nothing; the clock i_clk and reset i_rst_n must exist where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define PCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dispatcher assertion failed");

// Next-cycle implication, checked out of reset.
`define PCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dispatcher assertion failed");

`else

`define PCD_ASSERT_NOW(label, ante, cons)
`define PCD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/pcd_pkg.sv
// Types and constants of the priority capacity dispatcher.
// Used by pcd_select, the top level and the bench; pcd_ram does not use it. Depends on nothing.
package pcd_pkg;

    localparam int unsigned NEED_W     = 16;
    localparam int unsigned WAIT_W     = 5;
    localparam int unsigned WIDX_W     = 2;
    localparam int unsigned PRIO_W     = 8;
    localparam int unsigned PRIO_BUS_W = 32;
    localparam int unsigned CAP_BUS_W  = 64;
    localparam int unsigned RETRY_W    = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd10;

    // Command modes.
    localparam logic [1:0] MODE_ENQUEUE  = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_COMPLETE = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_QUEUED     = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_DISPATCHED = 3'd2;
    localparam logic [2:0] ST_REJECTED   = 3'd3;
    localparam logic [2:0] ST_DEFERRED   = 3'd4;
    localparam logic [2:0] ST_EMPTY      = 3'd5;
    localparam logic [2:0] ST_FREED      = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY      = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [NEED_W-1:0] resource_need;
        logic [WIDX_W-1:0] worker_index;
    } t_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic [WIDX_W-1:0] chosen_worker;
        logic [NEED_W-1:0] request_need;
        logic [WAIT_W-1:0] wait_count;
    } t_result;

    // One queue entry as stored in the RAM.
    typedef struct packed {
        logic [NEED_W-1:0] need;
        logic [WAIT_W-1:0] wait_count;
    } t_entry;

    // Outcome of the worker search.
    typedef struct packed {
        logic              found;
        logic [WIDX_W-1:0] idx;
    } t_sel;

endpackage

>>> rtl/core/pcd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pcd_ram #(
    parameter int unsigned WIDTH = 21,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pcd_select.sv
// Worker search: the idle worker with enough capacity and the highest priority,
// lowest index on a tie. Depends on pcd_pkg.
module pcd_select #(
    parameter int unsigned WORKERS = 4
) (
    input  logic [pcd_pkg::NEED_W-1:0]     i_need,
    input  logic [WORKERS-1:0]             i_idle,
    input  logic [pcd_pkg::PRIO_BUS_W-1:0] i_prio,
    input  logic [pcd_pkg::CAP_BUS_W-1:0]  i_cap,
    output pcd_pkg::t_sel                  o_sel
);

    always_comb begin
        logic [pcd_pkg::PRIO_W-1:0] best_pri;
        logic [pcd_pkg::PRIO_W-1:0] pri;
        logic [pcd_pkg::NEED_W-1:0] cap;
        best_pri = '0;
        o_sel    = '0;
        for (int i = 0; i < WORKERS; i++) begin
            pri = i_prio[pcd_pkg::PRIO_W*i +: pcd_pkg::PRIO_W];
            cap = i_cap[pcd_pkg::NEED_W*i +: pcd_pkg::NEED_W];
            // Strictly greater keeps the lower index on a tie.
            if (i_idle[i] && (cap >= i_need) && (!o_sel.found || (pri > best_pri))) begin
                o_sel.found = 1'b1;
                o_sel.idx   = pcd_pkg::WIDX_W'(i);
                best_pri    = pri;
            end
        end
    end

endmodule

>>> rtl/core/priority_capacity_dispatcher.sv
// Top level of the priority capacity dispatcher: request queue, worker state
// and configuration. Depends on pcd_pkg, pcd_ram, pcd_select, assert_macros.svh.
//
// Usage:
//   Commands enter on i_cmd and are taken at a rising edge with start high and
//   busy low. Each command except mode 3 gives one result on o_result, valid
//   for exactly one cycle while o_result_strobe is high; the receiver cannot
//   stall, so every result must be taken as it appears.
//   Enqueue, completion and a dispatch on an empty queue give their result in
//   the cycle after the command beat. A dispatch on a non-empty queue reads the
//   head entry from the queue RAM first, holds busy high for one cycle and
//   gives its result once the entry is back, through the result register. The
//   registered read of the queue RAM causes this extra step; a new command may
//   follow as soon as busy is low.
//   Configuration beats on the i_cfg_* channel are always taken (o_cfg_ready
//   is high) and must be sent while no command is in flight.
//   Synchronous reset empties the queue, marks all workers idle, clears the
//   priorities and capacities and sets the retry limit to ten. Queue RAM
//   contents are not cleared; only written entries are ever read.
`include "assert_macros.svh"

module priority_capacity_dispatcher #(
    parameter int unsigned WORKERS     = 4,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  pcd_pkg::t_cmd                    i_cmd,
    output logic                             o_result_strobe,
    output pcd_pkg::t_result                 o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned AW      = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ENTRY_W = $bits(pcd_pkg::t_entry);

    typedef enum logic {
        S_IDLE,
        S_DISP
    } t_state;

    t_state                            r_state, n_state;
    logic [AW-1:0]                     r_head, n_head;
    logic [AW-1:0]                     r_tail, n_tail;
    logic [FW-1:0]                     r_fill, n_fill;
    logic [WORKERS-1:0]                r_busy_flags, n_busy_flags;
    logic [pcd_pkg::PRIO_BUS_W-1:0]    r_prio;
    logic [pcd_pkg::CAP_BUS_W-1:0]     r_cap;
    logic [pcd_pkg::RETRY_W-1:0]       r_retry;
    logic                              r_strobe, n_strobe;
    pcd_pkg::t_result                  r_result, n_result;

    logic                              w_accept;
    logic                              w_full;
    logic                              w_we;
    pcd_pkg::t_entry                   w_wdata;
    logic                              w_re;
    pcd_pkg::t_entry                   w_head_entry;
    logic [ENTRY_W-1:0]                w_rdata;
    pcd_pkg::t_sel                     w_sel;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        if (ptr == AW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    assign busy        = (r_state == S_DISP);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_full      = (r_fill == FW'(QUEUE_DEPTH));
    assign w_re        = w_accept && (i_cmd.mode == pcd_pkg::MODE_DISPATCH);
    assign w_head_entry = pcd_pkg::t_entry'(w_rdata);

    pcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    pcd_select #(
        .WORKERS (WORKERS)
    ) u_select (
        .i_need (w_head_entry.need),
        .i_idle (~r_busy_flags),
        .i_prio (r_prio),
        .i_cap  (r_cap),
        .o_sel  (w_sel)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_busy_flags = r_busy_flags;
        n_strobe     = 1'b0;
        n_result     = r_result;
        w_we         = 1'b0;
        w_wdata      = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_result = '0;
                    case (i_cmd.mode)
                        pcd_pkg::MODE_ENQUEUE: begin
                            n_strobe              = 1'b1;
                            n_result.request_need = i_cmd.resource_need;
                            if (w_full) begin
                                n_result.status = pcd_pkg::ST_FULL;
                            end else begin
                                n_result.status = pcd_pkg::ST_QUEUED;
                                w_we            = 1'b1;
                                w_wdata.need    = i_cmd.resource_need;
                                n_tail          = ptr_inc(r_tail);
                                n_fill          = r_fill + 1'b1;
                            end
                        end
                        pcd_pkg::MODE_DISPATCH: begin
                            if (r_fill == '0) begin
                                n_strobe        = 1'b1;
                                n_result.status = pcd_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DISP;
                            end
                        end
                        pcd_pkg::MODE_COMPLETE: begin
                            n_strobe               = 1'b1;
                            n_result.status        = pcd_pkg::ST_FREED;
                            n_result.chosen_worker = i_cmd.worker_index;
                            for (int i = 0; i < WORKERS; i++) begin
                                if (i_cmd.worker_index == pcd_pkg::WIDX_W'(i)) begin
                                    n_busy_flags[i] = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DISP: begin
                // The head entry arrived from the RAM this cycle.
                n_state               = S_IDLE;
                n_strobe              = 1'b1;
                n_result              = '0;
                n_result.request_need = w_head_entry.need;
                n_result.wait_count   = w_head_entry.wait_count;
                n_head                = ptr_inc(r_head);
                if (w_sel.found) begin
                    n_result.status        = pcd_pkg::ST_DISPATCHED;
                    n_result.chosen_worker = w_sel.idx;
                    n_fill                 = r_fill - 1'b1;
                    for (int i = 0; i < WORKERS; i++) begin
                        if (w_sel.idx == pcd_pkg::WIDX_W'(i)) begin
                            n_busy_flags[i] = 1'b1;
                        end
                    end
                end else if (w_head_entry.wait_count >
                             pcd_pkg::WAIT_W'(r_retry)) begin
                    n_result.status = pcd_pkg::ST_REJECTED;
                    n_fill          = r_fill - 1'b1;
                end else begin
                    // Move to the tail; the fill count stays the same.
                    n_result.status     = pcd_pkg::ST_DEFERRED;
                    n_result.wait_count = w_head_entry.wait_count + 1'b1;
                    w_we                = 1'b1;
                    w_wdata.need        = w_head_entry.need;
                    w_wdata.wait_count  = w_head_entry.wait_count + 1'b1;
                    n_tail              = ptr_inc(r_tail);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_fill       <= '0;
            r_busy_flags <= '0;
            r_prio       <= '0;
            r_cap        <= '0;
            r_retry      <= pcd_pkg::RETRY_RESET;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_fill       <= n_fill;
            r_busy_flags <= n_busy_flags;
            r_strobe     <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pcd_pkg::CFG_PRIORITIES: r_prio  <= i_cfg_data[pcd_pkg::PRIO_BUS_W-1:0];
                    pcd_pkg::CFG_CAPACITIES: r_cap   <= i_cfg_data[pcd_pkg::CAP_BUS_W-1:0];
                    pcd_pkg::CFG_RETRY:      r_retry <= i_cfg_data[pcd_pkg::RETRY_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_result <= n_result;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    `PCD_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FW'(QUEUE_DEPTH))
    `PCD_ASSERT_NEXT(a_disp_one_cycle, busy, !busy && o_result_strobe)
    `PCD_ASSERT_NEXT(a_disp_reads_head,
        w_accept && (i_cmd.mode == pcd_pkg::MODE_DISPATCH) && (r_fill != '0), busy)
    `PCD_ASSERT_NEXT(a_enqueue_grows,
        w_accept && (i_cmd.mode == pcd_pkg::MODE_ENQUEUE) && !w_full,
        r_fill == $past(r_fill) + 1'b1)

endmodule

>>> bench/dispatch_checker.sv
// Checker for the priority capacity dispatcher: watches the command, result and register
// channels, predicts every result in order and compares it field by field.
// Depends on pcd_pkg.
module dispatch_checker
    import pcd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  t_cmd                    i_cmd,
    input  logic                    i_result_strobe,
    input  t_result                 i_result,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_pending,
    output int                      o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = 16;

    // Shadow copy of the block's queue, worker and register state.
    logic [NEED_W-1:0]     need_mem [QDEPTH];
    logic [WAIT_W-1:0]     wait_mem [QDEPTH];
    logic [3:0]            head_idx;
    logic [3:0]            tail_idx;
    logic [4:0]            fill;
    logic [3:0]            busy_mask;
    logic [PRIO_BUS_W-1:0] prio_reg;
    logic [CAP_BUS_W-1:0]  cap_reg;
    logic [RETRY_W-1:0]    retry_reg;

    t_result due_results[$];
    int      fails = 0;

    // Applies one command to the shadow state. Returns 0 for the unused mode,
    // which leaves everything alone and gives no result.
    function automatic bit dispatch_outcome(input t_cmd c, output t_result r);
        logic [NEED_W-1:0] need;
        logic [WAIT_W-1:0] wc;
        logic              found;
        logic [1:0]        best;
        logic [7:0]        best_pri;
        logic [7:0]        pri;
        logic [15:0]       cap;
        r        = '0;
        found    = 1'b0;
        best     = '0;
        best_pri = '0;
        case (c.mode)
            MODE_ENQUEUE: begin
                r.request_need = c.resource_need;
                if (fill >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    need_mem[tail_idx] = c.resource_need;
                    wait_mem[tail_idx] = '0;
                    tail_idx++;
                    fill++;
                    r.status = ST_QUEUED;
                end
            end
            MODE_DISPATCH: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    need = need_mem[head_idx];
                    wc   = wait_mem[head_idx];
                    for (int i = 0; i < 4; i++) begin
                        pri = prio_reg[8*i +: 8];
                        cap = cap_reg[16*i +: 16];
                        if (!busy_mask[i] && cap >= need && (!found || pri > best_pri)) begin
                            found    = 1'b1;
                            best     = i[1:0];
                            best_pri = pri;
                        end
                    end
                    head_idx++;
                    fill--;
                    r.request_need = need;
                    if (found) begin
                        busy_mask[best] = 1'b1;
                        r.status        = ST_DISPATCHED;
                        r.chosen_worker = best;
                        r.wait_count    = wc;
                    end else if (wc > retry_reg) begin
                        r.status     = ST_REJECTED;
                        r.wait_count = wc;
                    end else begin
                        // The head goes back to the tail with one more wait.
                        need_mem[tail_idx] = need;
                        wait_mem[tail_idx] = wc + 1'b1;
                        tail_idx++;
                        fill++;
                        r.status     = ST_DEFERRED;
                        r.wait_count = wc + 1'b1;
                    end
                end
            end
            MODE_COMPLETE: begin
                busy_mask[c.worker_index] = 1'b0;
                r.status        = ST_FREED;
                r.chosen_worker = c.worker_index;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result due;
        t_result nxt;
        if (!i_rst_n) begin
            head_idx  = '0;
            tail_idx  = '0;
            fill      = '0;
            busy_mask = '0;
            prio_reg  = '0;
            cap_reg   = '0;
            retry_reg = RETRY_RESET;
            due_results.delete();
        end else begin
            if (i_result_strobe) begin
                if (due_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d", i_result.status);
                    fails++;
                end else begin
                    due = due_results.pop_front();
                    compare_field("status", due.status, i_result.status);
                    compare_field("chosen_worker", due.chosen_worker, i_result.chosen_worker);
                    compare_field("request_need", due.request_need, i_result.request_need);
                    compare_field("wait_count", due.wait_count, i_result.wait_count);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRIORITIES: prio_reg  = i_cfg_data[PRIO_BUS_W-1:0];
                    CFG_CAPACITIES: cap_reg   = i_cfg_data[CAP_BUS_W-1:0];
                    CFG_RETRY:      retry_reg = i_cfg_data[RETRY_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (dispatch_outcome(i_cmd, nxt))
                    due_results.push_back(nxt);
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
    end

endmodule

>>> bench/priority_capacity_dispatcher_test.sv
// Top of the dispatcher testbench: clock, reset, command and register stimulus, verdict.
// Depends on pcd_pkg, priority_capacity_dispatcher and dispatch_checker.
module priority_capacity_dispatcher_test;
    import pcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 300;
    localparam int PHASE_ITEMS   = 100;
    localparam int RANDOM_PHASES = 8;

    // Command mixes of the random phases.
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_AGING } t_mix;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_cmd                  i_cmd;
    logic                  o_result_strobe;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int pending;
    int fail_total;
    int quiet_cycles = 0;

    logic [CAP_BUS_W-1:0] cur_caps = '0;
    bit                   sparse_gaps = 1'b0;

    priority_capacity_dispatcher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    dispatch_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (i_cmd),
        .i_result_strobe (o_result_strobe),
        .i_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_pending       (pending),
        .o_fail_count    (fail_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sends one command beat after a random gap; start stays high when no gap is drawn.
    task automatic issue(input logic [1:0] mode, input logic [NEED_W-1:0] need,
                         input logic [WIDX_W-1:0] widx);
        int   gap;
        t_cmd c;
        gap = (sparse_gaps && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 18);
        c.mode          = mode;
        c.resource_need = need;
        c.worker_index  = widx;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    // Waits until every expected result has come, then lets a dispatch in flight finish.
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Unused upper data bits carry noise; the block must ignore them.
    task automatic program_regs(input logic [PRIO_BUS_W-1:0] prio,
                                input logic [CAP_BUS_W-1:0] caps,
                                input logic [RETRY_W-1:0] retry);
        logic [CFG_DATA_W-1:0] word;
        drain();
        cur_caps = caps;
        cfg_beat(CFG_PRIORITIES, {$urandom, prio});
        cfg_beat(CFG_CAPACITIES, caps);
        word = {$urandom, $urandom};
        word[RETRY_W-1:0] = retry;
        cfg_beat(CFG_RETRY, word);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [NEED_W-1:0] pick_need();
        int          w;
        logic [15:0] cap;
        w   = $urandom_range(0, 3);
        cap = cur_caps[16*w +: 16];
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            // Right at or one past a worker's capacity.
            3: return cap + 16'($urandom_range(0, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_mode(input t_mix mix);
        int r;
        int enq;
        int disp;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin enq = 60; disp = 25; end
            MIX_DRAIN: begin enq = 20; disp = 60; end
            MIX_AGING: begin enq = 10; disp = 85; end
            default:   begin enq = 35; disp = 40; end
        endcase
        if (r < enq)
            return MODE_ENQUEUE;
        else if (r < enq + disp)
            return MODE_DISPATCH;
        else if (r < 97)
            return MODE_COMPLETE;
        else
            return MODE_UNUSED;
    endfunction

    initial begin : stimulus
        int          served;
        t_mix        mix;
        logic [1:0]  mode;
        logic [63:0] caps;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: all priorities and capacities zero, so only a zero need fits.
        issue(MODE_DISPATCH, 16'h1234, 2'd0);   // empty queue
        issue(MODE_COMPLETE, 16'h0000, 2'd3);   // completion of an idle worker
        issue(MODE_UNUSED,   16'hFFFF, 2'd3);   // ignored command
        issue(MODE_ENQUEUE,  16'h0000, 2'd0);
        issue(MODE_ENQUEUE,  16'hFFFF, 2'd1);
        issue(MODE_DISPATCH, 16'h0000, 2'd0);   // tie on priority zero, worker 0 wins
        issue(MODE_DISPATCH, 16'h0000, 2'd0);   // nothing fits, deferred
        issue(MODE_COMPLETE, 16'h0000, 2'd0);

        // Workers 1 and 2 tie at priority 5; only worker 3 at priority 0 takes the big need.
        program_regs(32'h0005_0500, 64'hFFFF_0100_0100_0000, 4'd0);
        issue(MODE_DISPATCH, 16'h0000, 2'd0);
        issue(MODE_ENQUEUE,  16'h0080, 2'd0);
        issue(MODE_DISPATCH, 16'h0000, 2'd0);
        issue(MODE_ENQUEUE,  16'h0200, 2'd2);
        issue(MODE_DISPATCH, 16'h0000, 2'd0);   // deferred once
        issue(MODE_DISPATCH, 16'h0000, 2'd0);   // wait count above the limit, rejected
        issue(MODE_COMPLETE, 16'h0000, 2'd1);
        issue(MODE_COMPLETE, 16'h0000, 2'd3);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sparse_gaps = p[0];
            case (p)
                0: begin
                    program_regs('1, '1, 4'd15);
                    mix = MIX_FILL;
                end
                1: begin
                    program_regs('0, '0, 4'd0);
                    mix = MIX_BALANCED;
                end
                2: begin
                    // Nothing but a zero need ever fits, so requests age up to the top count.
                    program_regs($urandom, '0, 4'd15);
                    mix = MIX_AGING;
                end
                default: begin
                    caps = {$urandom, $urandom};
                    if (p[0])
                        caps = caps & 64'h03FF_03FF_03FF_03FF;
                    program_regs($urandom, caps, 4'($urandom_range(0, 15)));
                    mix = t_mix'(p % 3);
                end
            endcase
            served = 0;
            while (served < PHASE_ITEMS) begin
                mode = pick_mode(mix);
                issue(mode, pick_need(), 2'($urandom_range(0, 3)));
                if (mode != MODE_UNUSED)
                    served++;
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_total == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
